// File: src/ppci_pkg.sv
// Shared types, constants and state codes for the particle integrator.
package ppci_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CFL_SHIFT   = 32 - FRAC_BITS;
  localparam int DIV_W       = 64 - CFL_SHIFT;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int SQRT_STEPS  = 32;
  localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
  localparam int NUM_LANES   = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_DIST = 1'b1;

  localparam logic [31:0] PART_DIST_RESET = 32'd65536;

  typedef struct packed {
    logic              func;
    logic              is_fluid;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic              last;
  } ppci_in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic        [31:0] max_speed;
    logic        [31:0] cfl_number;
    logic               pass_done;
  } ppci_out_t;

  typedef struct packed {
    logic mul1;
    logic add1;
    logic mul2;
    logic add2;
  } lane_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_ADD1,
    ST_MUL2,
    ST_ADD2,
    ST_MAX,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_CFL_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } ppci_state_t;

endpackage

// File: src/ppci_lane.sv
// One vector-component lane: velocity and position update for x, y or z.
module ppci_lane import ppci_pkg::*; (
  input  logic               clk,
  input  lane_ctrl_t         ctrl,
  input  logic               func,
  input  logic               is_fluid,
  input  logic signed [31:0] vel,
  input  logic signed [31:0] acc,
  input  logic signed [31:0] pos,
  input  logic        [31:0] dt,
  input  logic        [31:0] dt2,
  output logic signed [31:0] new_vel,
  output logic signed [31:0] new_pos,
  output logic        [63:0] speed_sq
);

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    logic signed [32:0] s;
    s = 33'(x) + 33'(y);
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  // round half up, keep upper word
  function automatic logic signed [31:0] rnd_hi(input logic signed [63:0] x);
    logic [63:0] t;
    t = 64'(x) + 64'h0000_0000_8000_0000;
    return t[63:32];
  endfunction

  logic signed [63:0] acc_e, vnew_e, dt_e, dt2_e;
  logic signed [63:0] dv_prod_r, dpc_prod_r, dpp_prod_r;
  logic signed [31:0] vnew_r, pcorr_r, pnew_r;
  logic        [63:0] sq_r;

  assign acc_e  = 64'(acc);
  assign vnew_e = 64'(vnew_r);
  assign dt_e   = $signed({32'b0, dt});
  assign dt2_e  = $signed({32'b0, dt2});

  always_ff @(posedge clk) begin
    if (ctrl.mul1) begin
      dv_prod_r  <= acc_e * dt_e;
      dpc_prod_r <= acc_e * dt2_e;
    end
    if (ctrl.add1) begin
      vnew_r  <= sat_add(vel, rnd_hi(dv_prod_r));
      pcorr_r <= sat_add(pos, rnd_hi(dpc_prod_r));
    end
    if (ctrl.mul2) begin
      dpp_prod_r <= vnew_e * dt_e;
      sq_r       <= 64'(vnew_e * vnew_e);
    end
    if (ctrl.add2) begin
      pnew_r <= func ? pcorr_r : sat_add(pos, rnd_hi(dpp_prod_r));
    end
  end

  assign new_vel  = is_fluid ? vnew_r : vel;
  assign new_pos  = is_fluid ? pnew_r : pos;
  assign speed_sq = sq_r;

endmodule

// File: src/ppci_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module ppci_isqrt import ppci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0]           rad_r;
  logic [33:0]           rem_r, rem_nxt;
  logic [31:0]           root_r, root_nxt;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic                  busy_r, done_r;
  logic [35:0]           cur, trial;

  assign cur   = {rem_r, rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};

  always_comb begin
    if (cur >= trial) begin
      rem_nxt  = 34'(cur - trial);
      root_nxt = {root_r[30:0], 1'b1};
    end else begin
      rem_nxt  = 34'(cur);
      root_nxt = {root_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[61:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

// File: src/ppci_div.sv
// Restoring divider, one quotient bit per cycle.
module ppci_div import ppci_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     dvd_r, quot_r;
  logic [31:0]          rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [32:0]          cur;
  logic                 fits;

  assign cur  = {rem_r, dvd_r[DIV_W-1]};
  assign fits = (cur >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // zero divisor: every trial fits, quotient comes out all ones
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[DIV_W-2:0], 1'b0};
      rem_r  <= fits ? 32'(cur - {1'b0, divisor}) : cur[31:0];
      quot_r <= {quot_r[DIV_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// File: src/particle_predict_correct_integrator_core.sv
// Top level: particle integrator with three component lanes and CFL monitor.
//
//  channel | ports                              | transfer when
//  --------+------------------------------------+----------------------------
//  input   | in_valid, in_stall, in_data        | in_valid && !in_stall
//  result  | out_valid, out_stall, out_data     | out_valid && !out_stall
//  config  | cfg_we, cfg_index, cfg_wdata       | cfg_we
//
// One transaction is worked at a time by a sequencer driving three lanes
// (x, y, z), each a multiply / saturating-add pipeline of four steps.
// Ordinary item: after acceptance the sequencer steps MUL1, ADD1, MUL2, ADD2, MAX
// and DONE, then returns to IDLE. End of a correct pass: after MAX come the 32-step
// square root, the CFL multiply and the DIV_W-step restoring divider, then DONE.
// Reset (rst_n low, synchronous) closes any pass, zeroes the max squared speed and
// loads time_step = 0, particle_distance = 1.0.
// The result sits in an output register; the next input transaction is
// taken while it waits, and only the final hand-off stalls on out_stall.
module particle_predict_correct_integrator_core import ppci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ppci_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ppci_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  ppci_state_t state_r, state_nxt;

  // configuration, dt squared is kept ready at write time
  logic [31:0] dt_r, dt2_r, dist_r;
  logic [63:0] dt_sq;

  ppci_in_t    item_r;
  logic        pass_open_r;
  logic [63:0] max_sq_r, sum_r;
  logic [31:0] mspeed_r, cfl_r;
  logic [63:0] cfl_prod_r;

  ppci_out_t   out_data_r, out_data_nxt;
  logic        out_valid_r;

  lane_ctrl_t  lane_ctrl;
  logic        in_accept, out_free, out_load, pass_end;
  logic        root_start, root_busy, root_done;
  logic        div_start, div_busy, div_done;
  logic [31:0] root_val;
  logic [DIV_W-1:0] quot;

  logic signed [31:0] vel_a  [NUM_LANES];
  logic signed [31:0] acc_a  [NUM_LANES];
  logic signed [31:0] pos_a  [NUM_LANES];
  logic signed [31:0] nvel_a [NUM_LANES];
  logic signed [31:0] npos_a [NUM_LANES];
  logic        [63:0] sq_a   [NUM_LANES];

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign pass_end  = item_r.func && item_r.last;

  // ---------------- configuration ----------------
  assign dt_sq = 64'(cfg_wdata) * 64'(cfg_wdata) + 64'h0000_0000_8000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r   <= '0;
      dt2_r  <= '0;
      dist_r <= PART_DIST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_STEP: begin
          dt_r  <= cfg_wdata;
          dt2_r <= dt_sq[63:32];
        end
        CFG_PARTICLE_DIST: dist_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- lanes ----------------
  assign vel_a[0] = item_r.vel_x;
  assign vel_a[1] = item_r.vel_y;
  assign vel_a[2] = item_r.vel_z;
  assign acc_a[0] = item_r.acc_x;
  assign acc_a[1] = item_r.acc_y;
  assign acc_a[2] = item_r.acc_z;
  assign pos_a[0] = item_r.pos_x;
  assign pos_a[1] = item_r.pos_y;
  assign pos_a[2] = item_r.pos_z;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    ppci_lane u_lane (
      .clk      (clk),
      .ctrl     (lane_ctrl),
      .func     (item_r.func),
      .is_fluid (item_r.is_fluid),
      .vel      (vel_a[g]),
      .acc      (acc_a[g]),
      .pos      (pos_a[g]),
      .dt       (dt_r),
      .dt2      (dt2_r),
      .new_vel  (nvel_a[g]),
      .new_pos  (npos_a[g]),
      .speed_sq (sq_a[g])
    );
  end

  // ---------------- end-of-pass units ----------------
  ppci_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (max_sq_r),
    .busy     (root_busy),
    .done     (root_done),
    .root     (root_val)
  );

  ppci_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cfl_prod_r[63:CFL_SHIFT]),
    .divisor  (dist_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_MUL1;
      ST_MUL1:      state_nxt = ST_ADD1;
      ST_ADD1:      state_nxt = ST_MUL2;
      ST_MUL2:      state_nxt = ST_ADD2;
      ST_ADD2:      state_nxt = ST_MAX;
      ST_MAX:       state_nxt = pass_end ? ST_ROOT_GO : ST_DONE;
      ST_ROOT_GO:   state_nxt = ST_ROOT_WAIT;
      ST_ROOT_WAIT: if (root_done) state_nxt = ST_CFL_MUL;
      ST_CFL_MUL:   state_nxt = ST_DIV_GO;
      ST_DIV_GO:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lane_ctrl  = '0;
    root_start = 1'b0;
    div_start  = 1'b0;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE:    in_stall       = 1'b0;
      ST_MUL1:    lane_ctrl.mul1 = 1'b1;
      ST_ADD1:    lane_ctrl.add1 = 1'b1;
      ST_MUL2:    lane_ctrl.mul2 = 1'b1;
      ST_ADD2:    lane_ctrl.add2 = 1'b1;
      ST_ROOT_GO: root_start     = 1'b1;
      ST_DIV_GO:  div_start      = 1'b1;
      ST_DONE:    out_load       = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- item, merge and pass state ----------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    // merge stage: sum of the three lane squares
    if (state_r == ST_ADD2) begin
      sum_r <= sq_a[0] + sq_a[1] + sq_a[2];
    end
    if (state_r == ST_ROOT_WAIT && root_done) begin
      mspeed_r <= root_val;
    end
    if (state_r == ST_CFL_MUL) begin
      cfl_prod_r <= 64'(dt_r) * 64'(mspeed_r);
    end
    if (state_r == ST_DIV_WAIT && div_done) begin
      cfl_r <= (|quot[DIV_W-1:32]) ? 32'hFFFF_FFFF : quot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_open_r <= 1'b0;
      max_sq_r    <= '0;
    end else begin
      if (in_accept && in_data.func && !pass_open_r) begin
        pass_open_r <= 1'b1;
        max_sq_r    <= '0;
      end
      if (state_r == ST_MAX && item_r.func && item_r.is_fluid && sum_r > max_sq_r) begin
        max_sq_r <= sum_r;
      end
      if (out_load && pass_end) begin
        pass_open_r <= 1'b0;
      end
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_data_nxt.new_vel_x  = nvel_a[0];
    out_data_nxt.new_vel_y  = nvel_a[1];
    out_data_nxt.new_vel_z  = nvel_a[2];
    out_data_nxt.new_pos_x  = npos_a[0];
    out_data_nxt.new_pos_y  = npos_a[1];
    out_data_nxt.new_pos_z  = npos_a[2];
    out_data_nxt.max_speed  = pass_end ? mspeed_r : '0;
    out_data_nxt.cfl_number = pass_end ? cfl_r : '0;
    out_data_nxt.pass_done  = pass_end;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.func && !pass_open_r) |=> (pass_open_r && max_sq_r == '0))
    else $error("pass start did not open pass and clear max");

  a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (pass_open_r && $past(pass_open_r)) |-> (max_sq_r >= $past(max_sq_r)))
    else $error("max squared speed dropped inside a pass");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.pass_done) |->
      (out_data.max_speed == '0 && out_data.cfl_number == '0))
    else $error("pass results on an ordinary transaction");

  a_root_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT_WAIT) |-> (root_busy || root_done))
    else $error("waiting on an idle square root unit");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_WAIT) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

endmodule
